// ===== hw/rtl/vad_pkg.sv =====
// Shared constants and the CORDIC angle table for the vector angle block.
`default_nettype none
package vad_pkg;

  localparam int ZW = 26;
  localparam int ONE_Q = 256;
  localparam int ROUND_HALF = 128;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam logic signed [ZW-1:0] DEG90_Q16 = 26'sd5898240;
  localparam logic signed [ZW-1:0] DEG180_Q16 = 26'sd11796480;
  localparam logic [15:0] ANGLE_MAX = 16'd46080;

  // Arctangent of 2^-idx in degrees with 16 fraction bits.
  function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    case (idx)
      5'd0: r = 26'sd2949120;
      5'd1: r = 26'sd1740967;
      5'd2: r = 26'sd919879;
      5'd3: r = 26'sd466945;
      5'd4: r = 26'sd234379;
      5'd5: r = 26'sd117304;
      5'd6: r = 26'sd58666;
      5'd7: r = 26'sd29335;
      5'd8: r = 26'sd14668;
      5'd9: r = 26'sd7334;
      5'd10: r = 26'sd3667;
      5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;
      5'd13: r = 26'sd458;
      5'd14: r = 26'sd229;
      5'd15: r = 26'sd115;
      5'd16: r = 26'sd57;
      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;
      5'd19: r = 26'sd7;
      5'd20: r = 26'sd4;
      5'd21: r = 26'sd2;
      5'd22: r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vector_angle_degrees.sv =====
// Top level of the unsigned angle between two 2-D vectors, in Q8.8 degrees.
//
// Input beats carry cmd, pos_x, pos_y, dir_x and dir_y; a beat is taken at a
// rising edge with in_valid high and in_stall low. Output beats carry
// angle_deg and degenerate and are taken when out_valid is high and
// out_stall is low. Each input beat gives exactly one output beat, in order.
// The block takes one beat per cycle while in_stall is low; its pipeline has one
// stage per CORDIC step. Two front stages form the products and the dot and
// cross terms, then a four-entry queue feeds the back end, which folds the
// quadrant, runs the CORDIC steps and rounds the angle.
// When out_stall is high the back end holds its results; the queue absorbs
// the beats still in the front end, and in_stall rises once it is full.
// Synchronous reset empties the pipeline and the queue; no item survives.
// A zero-length vector gives degenerate high and angle 0.
`default_nettype none
module vector_angle_degrees #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              cmd,
  input  wire logic signed [COMPONENT_WIDTH-1:0] pos_x,
  input  wire logic signed [COMPONENT_WIDTH-1:0] pos_y,
  input  wire logic signed [COMPONENT_WIDTH-1:0] dir_x,
  input  wire logic signed [COMPONENT_WIDTH-1:0] dir_y,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [15:0]                            angle_deg,
  output logic                                   degenerate
);

  localparam int W = COMPONENT_WIDTH;
  localparam int PW = (2 * W > W + 10) ? 2 * W : W + 10;
  localparam int DW = 2 * (PW + 1) + 1;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  logic [DW-1:0] q_wr_data;
  logic [DW-1:0] q_rd_data;

  vad_front #(
    .W(W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .dir_x(dir_x),
    .dir_y(dir_y),
    .q_push(q_push),
    .q_full(q_full),
    .q_data(q_wr_data)
  );

  vad_queue #(
    .DW(DW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .wr_data(q_wr_data),
    .full(q_full),
    .pop(q_pop),
    .not_empty(q_valid),
    .rd_data(q_rd_data)
  );

  vad_back #(
    .W(W),
    .STEPS(CORDIC_STEPS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_pop(q_pop),
    .q_data(q_rd_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .angle_deg(angle_deg),
    .degenerate(degenerate)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/vad_front.sv =====
// Front end: accepts beats, forms the products, dot and cross, and flags zero vectors.
`default_nettype none
module vad_front #(
  parameter int W = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  cmd,
  input  wire logic signed [W-1:0]   pos_x,
  input  wire logic signed [W-1:0]   pos_y,
  input  wire logic signed [W-1:0]   dir_x,
  input  wire logic signed [W-1:0]   dir_y,
  output logic                       q_push,
  input  wire logic                  q_full,
  output logic [2*(((2*W > W+10) ? 2*W : W+10)+1):0] q_data
);

  localparam int OW = W + 2;
  localparam int PW = (2 * W > W + 10) ? 2 * W : W + 10;
  localparam int PS = (W > 29) ? 2 : 0;
  localparam int SW = PW + 1;

  logic en;
  logic accept;

  logic signed [OW-1:0] bx;
  logic signed [OW-1:0] by;
  logic signed [2*W-1:0] m_xx, m_yy, m_xy, m_yx;
  logic signed [PW-1:0] sh_bx, sh_by;
  logic signed [PW-1:0] c_xx, c_yy, c_xy, c_yx;
  logic c_degen;

  logic f1_valid;
  logic f1_degen;
  logic signed [PW-1:0] f1_xx, f1_yy, f1_xy, f1_yx;

  logic f2_valid;
  logic f2_degen;
  logic signed [SW-1:0] f2_dot, f2_cross;

  assign en = !(f2_valid && q_full);
  assign in_stall = !en;
  assign accept = in_valid && en;

  always_comb begin
    if (cmd) begin
      bx = OW'(dir_x) + OW'(vad_pkg::ONE_Q);
      by = OW'(dir_y) + OW'(vad_pkg::ONE_Q);
    end else begin
      bx = OW'(dir_x);
      by = OW'(dir_y);
    end
  end

  assign m_xx = pos_x * dir_x;
  assign m_yy = pos_y * dir_y;
  assign m_xy = pos_x * dir_y;
  assign m_yx = pos_y * dir_x;
  assign sh_bx = PW'(bx) <<< 8;
  assign sh_by = PW'(by) <<< 8;

  always_comb begin
    if (cmd) begin
      c_xx = sh_bx;
      c_yy = sh_by;
      c_xy = sh_by;
      c_yx = sh_bx;
      c_degen = (bx == '0) && (by == '0);
    end else begin
      c_xx = PW'(m_xx);
      c_yy = PW'(m_yy);
      c_xy = PW'(m_xy);
      c_yx = PW'(m_yx);
      c_degen = ((pos_x == '0) && (pos_y == '0)) || ((bx == '0) && (by == '0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= accept;
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_xx <= c_xx;
      f1_yy <= c_yy;
      f1_xy <= c_xy;
      f1_yx <= c_yx;
      f1_degen <= c_degen;
      f2_dot <= SW'(f1_xx >>> PS) + SW'(f1_yy >>> PS);
      f2_cross <= SW'(f1_xy >>> PS) - SW'(f1_yx >>> PS);
      f2_degen <= f1_degen;
    end
  end

  assign q_push = f2_valid && !q_full;
  assign q_data = {f2_degen, f2_dot, f2_cross};

endmodule
`default_nettype wire

// ===== hw/rtl/vad_queue.sv =====
// Short queue between the front end and the CORDIC back end.
`default_nettype none
module vad_queue #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [DW-1:0] wr_data,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output logic [DW-1:0]      rd_data
);

  logic [DW-1:0] mem [vad_pkg::Q_DEPTH];
  logic [vad_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [vad_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [vad_pkg::Q_CNT_W-1:0] count;
  logic do_pop;

  assign full = (count == vad_pkg::Q_CNT_W'(vad_pkg::Q_DEPTH));
  assign not_empty = (count != '0);
  assign do_pop = pop && not_empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vad_back.sv =====
// Back end: quadrant fold, pipelined vectoring CORDIC, and rounding to Q8.8 degrees.
`default_nettype none
module vad_back #(
  parameter int W = 16,
  parameter int STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  wire logic [2*(((2*W > W+10) ? 2*W : W+10)+1):0] q_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      angle_deg,
  output logic             degenerate
);

  localparam int PW = (2 * W > W + 10) ? 2 * W : W + 10;
  localparam int SW = PW + 1;
  localparam int CW = PW + 3;
  localparam int ZW = vad_pkg::ZW;

  logic en;
  logic [STEPS+1:0] v;

  logic signed [SW-1:0] in_dot, in_cross;
  logic in_degen;
  logic signed [CW-1:0] cross_ext, dot_ext, cross_abs;

  logic signed [CW-1:0] x [STEPS+1];
  logic signed [CW-1:0] y [STEPS+1];
  logic signed [ZW-1:0] z [STEPS+1];
  logic dg [STEPS+1];

  logic signed [ZW-1:0] z_clamp;
  logic [ZW-1:0] z_round;
  logic [ZW-9:0] ang_wide;
  logic [15:0] ang_c;

  logic [15:0] ang_r;
  logic dg_r;

  assign en = !(v[STEPS+1] && out_stall);
  assign q_pop = en && q_valid;

  assign in_degen = q_data[2*SW];
  assign in_dot = q_data[2*SW-1:SW];
  assign in_cross = q_data[SW-1:0];
  assign cross_ext = CW'(in_cross);
  assign dot_ext = CW'(in_dot);
  assign cross_abs = cross_ext[CW-1] ? -cross_ext : cross_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[STEPS:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dg[0] <= in_degen;
      if (dot_ext[CW-1]) begin
        x[0] <= cross_abs;
        y[0] <= -dot_ext;
        z[0] <= vad_pkg::DEG90_Q16;
      end else begin
        x[0] <= dot_ext;
        y[0] <= cross_abs;
        z[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;
    assign at = vad_pkg::atan_q16(5'(i));

    always_ff @(posedge clk) begin
      if (en) begin
        dg[i+1] <= dg[i];
        if (y[i] == '0) begin
          x[i+1] <= x[i];
          y[i+1] <= y[i];
          z[i+1] <= z[i];
        end else if (!y[i][CW-1]) begin
          x[i+1] <= x[i] + ys;
          y[i+1] <= y[i] - xs;
          z[i+1] <= z[i] + at;
        end else begin
          x[i+1] <= x[i] - ys;
          y[i+1] <= y[i] + xs;
          z[i+1] <= z[i] - at;
        end
      end
    end
  end

  always_comb begin
    if (z[STEPS][ZW-1]) begin
      z_clamp = '0;
    end else if (z[STEPS] > vad_pkg::DEG180_Q16) begin
      z_clamp = vad_pkg::DEG180_Q16;
    end else begin
      z_clamp = z[STEPS];
    end
    z_round = ZW'(z_clamp) + ZW'(vad_pkg::ROUND_HALF);
    ang_wide = z_round[ZW-1:8];
    if (ang_wide > (ZW-8)'(vad_pkg::ANGLE_MAX)) begin
      ang_c = vad_pkg::ANGLE_MAX;
    end else begin
      ang_c = ang_wide[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dg_r <= dg[STEPS];
      ang_r <= dg[STEPS] ? 16'd0 : ang_c;
    end
  end

  assign out_valid = v[STEPS+1];
  assign angle_deg = ang_r;
  assign degenerate = dg_r;

endmodule
`default_nettype wire
